[hw/rtl/npa_pkg.sv]
// Package for the page allocator: request and result types, codes and
// the command and status groups between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package npa_pkg;

  // Width of a page number on the request and result ports.
  localparam int unsigned PageW = 15;
  // Number of memory nodes with a free list of their own.
  localparam int unsigned NumNodes = 3;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_INIT   = 2'd2,
    MODE_ADDREF = 2'd3
  } npa_mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_ALLOC   = 3'd0,
    STS_FREED   = 3'd1,
    STS_REFD    = 3'd2,
    STS_NOMEM   = 3'd3,
    STS_BADADDR = 3'd4,
    STS_DOUBLE  = 3'd5,
    STS_CORRUPT = 3'd6,
    STS_REFADD  = 3'd7
  } npa_status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FIRST_PAGE = 2'd0,
    CFG_NODE1_FIRST = 2'd1,
    CFG_NODE2_FIRST = 2'd2
  } npa_cfg_e;

  // Node codes.
  localparam logic [1:0] Node0 = 2'd0;
  localparam logic [1:0] Node1 = 2'd1;
  localparam logic [1:0] Node2 = 2'd2;
  localparam logic [1:0] NodeNone = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [PageW-1:0] FirstPageRst = 15'd0;
  localparam logic [PageW-1:0] Node1FirstRst = 15'd10923;
  localparam logic [PageW-1:0] Node2FirstRst = 15'd21846;

  // One request.
  typedef struct packed {
    logic [1:0]       mode;
    logic [PageW-1:0] page_number;
    logic [1:0]       node;
  } npa_req_t;

  // One result.
  typedef struct packed {
    logic [PageW-1:0] page_number_res;
    logic [2:0]       status;
    logic [1:0]       node_used;
  } npa_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;  // clear one count entry per cycle
    logic load;   // latch the request and start the table reads
    logic exec;   // evaluate the request and update the tables
  } npa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is at its last entry
  } npa_sts_t;

endpackage

`default_nettype wire

[hw/rtl/npa_ctrl.sv]
// Controller of the page allocator: clearing pass, request sequencing and
// the result strobe. Depends on npa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npa_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire npa_pkg::npa_sts_t sts_i,
  output npa_pkg::npa_cmd_t     cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_EXEC);
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.clear = (state_q == ST_CLEAR);
    cmd_o.load  = (state_q == ST_IDLE) && start_i;
    cmd_o.exec  = (state_q == ST_EXEC);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

[hw/rtl/npa_dpath.sv]
// Datapath of the page allocator: configuration registers, list heads,
// next-page and count tables, request evaluation. Depends on npa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npa_dpath #(
  parameter int unsigned PAGE_COUNT = 32768,
  parameter int unsigned REF_BITS   = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire npa_pkg::npa_cmd_t         cmd_i,
  output npa_pkg::npa_sts_t              sts_o,
  input  wire npa_pkg::npa_req_t         req_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [npa_pkg::PageW-1:0] cfg_wdata_i,
  output npa_pkg::npa_res_t              res_o
);

  localparam int unsigned PW = npa_pkg::PageW;
  // Pages are carried in PW bits, so no table needs more entries than that.
  localparam int unsigned Depth = (PAGE_COUNT < (2 ** PW)) ? PAGE_COUNT : (2 ** PW);
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [REF_BITS-1:0] RefMax = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] RefOne = REF_BITS'(1);

  // Configuration registers.
  logic [PW-1:0] first_page_q, node1_first_q, node2_first_q;

  // Free list heads.
  logic [PW-1:0] list_head_q [npa_pkg::NumNodes];
  logic [PW-1:0] list_head_d [npa_pkg::NumNodes];
  logic          list_ne_q   [npa_pkg::NumNodes];
  logic          list_ne_d   [npa_pkg::NumNodes];

  // Tables: bit PW of a link marks a following page.
  logic [PW:0]          next_mem [Depth];
  logic [REF_BITS-1:0]  ref_mem  [Depth];
  logic [PW:0]          next_rd_q;
  logic [REF_BITS-1:0]  ref_rd_q;

  // Clearing pass counter.
  logic [AddrW-1:0] clr_cnt_q;

  // Latched request and list choice.
  npa_pkg::npa_req_t req_q;
  logic [1:0]        sel_q;
  logic              found_q;
  npa_pkg::npa_res_t res_q, res_d;

  // Table write ports.
  logic                ref_we, next_we;
  logic [AddrW-1:0]    ref_wa, next_wa;
  logic [REF_BITS-1:0] ref_wd;
  logic [PW:0]         next_wd;

  // List choice for an allocation.
  logic [1:0] ord0, ord1, ord2, pick;
  logic       found;

  // Evaluation temporaries.
  logic [PW-1:0]       page;
  logic [PW-1:0]       head_sel;
  logic [REF_BITS-1:0] c_eff;
  logic [1:0]          target;
  logic                go;

  function automatic logic in_range(input logic [PW-1:0] p, input logic [PW-1:0] lo);
    in_range = (p >= lo) && (32'(p) < 32'(PAGE_COUNT));
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q  <= npa_pkg::FirstPageRst;
      node1_first_q <= npa_pkg::Node1FirstRst;
      node2_first_q <= npa_pkg::Node2FirstRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        npa_pkg::CFG_FIRST_PAGE:  first_page_q  <= cfg_wdata_i;
        npa_pkg::CFG_NODE1_FIRST: node1_first_q <= cfg_wdata_i;
        npa_pkg::CFG_NODE2_FIRST: node2_first_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Search order: the requester's node first, then the others ascending.
  always_comb begin
    if (req_i.node == npa_pkg::NodeNone) begin
      ord0 = npa_pkg::Node0;
      ord1 = npa_pkg::Node1;
      ord2 = npa_pkg::Node2;
    end else begin
      ord0 = req_i.node;
      ord1 = (req_i.node == npa_pkg::Node0) ? npa_pkg::Node1 : npa_pkg::Node0;
      ord2 = (req_i.node == npa_pkg::Node2) ? npa_pkg::Node1 : npa_pkg::Node2;
    end
    found = 1'b1;
    if (list_ne_q[ord0]) begin
      pick = ord0;
    end else if (list_ne_q[ord1]) begin
      pick = ord1;
    end else if (list_ne_q[ord2]) begin
      pick = ord2;
    end else begin
      pick  = npa_pkg::Node0;
      found = 1'b0;
    end
  end

  // Latch the request and the chosen list.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_i;
      sel_q   <= pick;
      found_q <= found;
    end
  end

  // Registered table reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      next_rd_q <= next_mem[list_head_q[pick][AddrW-1:0]];
      ref_rd_q  <= ref_mem[req_i.page_number[AddrW-1:0]];
    end
  end

  // Table writes.
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
  end

  // Clearing pass over the count table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == AddrW'(Depth - 1));

  // Request evaluation.
  always_comb begin
    list_head_d = list_head_q;
    list_ne_d   = list_ne_q;
    ref_we      = 1'b0;
    ref_wa      = clr_cnt_q;
    ref_wd      = '0;
    next_we     = 1'b0;
    next_wa     = req_q.page_number[AddrW-1:0];
    next_wd     = '0;
    res_d       = res_q;
    page        = req_q.page_number;
    head_sel    = list_head_q[sel_q];
    c_eff       = ref_rd_q;
    target      = npa_pkg::Node0;
    go          = 1'b0;

    if (cmd_i.clear) begin
      ref_we = 1'b1;
    end else if (cmd_i.exec) begin
      res_d.page_number_res = page;
      res_d.node_used       = npa_pkg::Node0;
      res_d.status          = npa_pkg::STS_BADADDR;
      if (req_q.mode == npa_pkg::MODE_ALLOC) begin
        // Pop the chosen list unless its link leaves the page range.
        if (!found_q) begin
          res_d.page_number_res = '0;
          res_d.status          = npa_pkg::STS_NOMEM;
        end else begin
          res_d.page_number_res = head_sel;
          res_d.node_used       = sel_q;
          if (next_rd_q[PW] && !in_range(next_rd_q[PW-1:0], first_page_q)) begin
            res_d.status = npa_pkg::STS_CORRUPT;
          end else begin
            res_d.status       = npa_pkg::STS_ALLOC;
            list_head_d[sel_q] = next_rd_q[PW-1:0];
            list_ne_d[sel_q]   = next_rd_q[PW];
            ref_we             = 1'b1;
            ref_wa             = head_sel[AddrW-1:0];
            ref_wd             = RefOne;
          end
        end
      end else if (!in_range(page, first_page_q)) begin
        res_d.status = npa_pkg::STS_BADADDR;
      end else if (req_q.mode == npa_pkg::MODE_ADDREF) begin
        // Saturating increment.
        res_d.status = npa_pkg::STS_REFADD;
        ref_wa       = page[AddrW-1:0];
        if (ref_rd_q != RefMax) begin
          ref_we = 1'b1;
          ref_wd = ref_rd_q + RefOne;
        end
      end else begin
        if (req_q.mode == npa_pkg::MODE_FREE) begin
          // Runtime free: the owning node comes from the boundaries.
          if (page < node1_first_q) begin
            target = npa_pkg::Node0;
          end else if (page < node2_first_q) begin
            target = npa_pkg::Node1;
          end else begin
            target = npa_pkg::Node2;
          end
          if (ref_rd_q == '0) begin
            res_d.status    = npa_pkg::STS_DOUBLE;
            res_d.node_used = target;
          end else begin
            go = 1'b1;
          end
        end else if (req_q.node != npa_pkg::NodeNone) begin
          // Initial free takes a count of zero as one.
          target = req_q.node;
          go     = 1'b1;
          if (ref_rd_q == '0) begin
            c_eff = RefOne;
          end
        end

        if (go) begin
          res_d.node_used = target;
          ref_we          = 1'b1;
          ref_wa          = page[AddrW-1:0];
          if (c_eff > RefOne) begin
            res_d.status = npa_pkg::STS_REFD;
            ref_wd       = c_eff - RefOne;
          end else begin
            // Last reference gone: push the page onto the target list.
            res_d.status        = npa_pkg::STS_FREED;
            ref_wd              = '0;
            next_we             = 1'b1;
            next_wd             = list_ne_q[target] ? {1'b1, list_head_q[target]} : '0;
            list_head_d[target] = page;
            list_ne_d[target]   = 1'b1;
          end
        end
      end
    end
  end

  // List head registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < npa_pkg::NumNodes; i++) begin
        list_head_q[i] <= '0;
        list_ne_q[i]   <= 1'b0;
      end
    end else begin
      list_head_q <= list_head_d;
      list_ne_q   <= list_ne_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[hw/rtl/numa_page_allocator_refcount.sv]
// Top level of the page allocator for three memory nodes with reference
// counts. Instantiates npa_ctrl and npa_dpath; depends on npa_pkg.
//
//   channel   ports                                   transfer
//   request   start_i, busy_o, req_i                  start_i high while busy_o low
//   result    done_o, res_o                           done_o high for one cycle
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i        cfg_we_i high, no wait
//
// A request first has its next-page and count table entries read into
// registers, then is evaluated and writes the tables and list heads.
// The result strobe comes in the cycle after, together with busy_o low, so a
// new request is not taken before the last result. After reset the count
// table is cleared one entry a cycle, min(PAGE_COUNT, 32768) entries
// (32768 at the defaults), while busy_o stays high. The result side cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module numa_page_allocator_refcount #(
  parameter int unsigned PAGE_COUNT = 32768,
  parameter int unsigned REF_BITS   = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire npa_pkg::npa_req_t         req_i,
  output logic                           done_o,
  output npa_pkg::npa_res_t              res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [npa_pkg::PageW-1:0] cfg_wdata_i
);

  npa_pkg::npa_cmd_t cmd;
  npa_pkg::npa_sts_t sts;

  // Sequencing.
  npa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Tables and request evaluation.
  npa_dpath #(
    .PAGE_COUNT (PAGE_COUNT),
    .REF_BITS   (REF_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

[hw/rtl/npa_checker.sv]
// Port-level checks of the page allocator, bound to the top level.
// Depends on npa_pkg and numa_page_allocator_refcount.
`timescale 1ns / 1ps
`default_nettype none

module npa_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              done_o,
  input wire npa_pkg::npa_res_t res_o
);

  // An accepted request makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after an accepted request");

  // Every accepted request is followed by its result strobe.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result strobe missing two cycles after a request");

  // With the result the block is ready again.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("block still busy while showing a result");

  // A result strobe is never repeated back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // An empty allocation reports page zero on node zero.
  a_nomem_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == npa_pkg::STS_NOMEM)) |->
      ((res_o.page_number_res == '0) && (res_o.node_used == npa_pkg::Node0)))
    else $error("out-of-memory result with nonzero page or node");

endmodule

bind numa_page_allocator_refcount npa_checker u_npa_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for numa_page_allocator_refcount: directed requests, then random
// allocate/free/reference traffic over several boundary settings, checked against a predictor.
// Depends on npa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;
  import npa_pkg::*;

  localparam logic [7:0] RefMax = 8'hFF;

  // One directed row: the request, and a typed result where one is given.
  typedef struct packed {
    npa_req_t rq;
    logic     typed;
    npa_res_t res;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  npa_req_t         req_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = CFG_FIRST_PAGE;
  logic [PageW-1:0] cfg_wdata_i = '0;
  logic             busy_o;
  logic             done_o;
  npa_res_t         res_o;

  // Predictor state: boundaries, list heads and the two page tables.
  bit [PageW-1:0] low_page = FirstPageRst;
  bit [PageW-1:0] n1_start = Node1FirstRst;
  bit [PageW-1:0] n2_start = Node2FirstRst;
  bit [PageW-1:0] head_pg [NumNodes];
  bit             has_pages [NumNodes];
  bit [15:0]      link_tbl [32768];
  bit [7:0]       count_tbl [32768];

  npa_res_t       pending_results [$];
  logic [14:0]    held_pages [$];
  dir_row_t       dir_tbl [$];
  bit             idle_ok = 1'b1;
  int             mismatches = 0;

  numa_page_allocator_refcount dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Computes the result of one request and updates the allocator state.
  function automatic npa_res_t allocator_outcome(npa_req_t r);
    logic [1:0]  order [3];
    int          k;
    bit          found;
    logic [14:0] pg;
    logic [15:0] nx;
    logic [7:0]  cnt;
    logic [1:0]  tgt;
    npa_res_t    o;
    o = {15'd0, STS_NOMEM, Node0};
    pg = r.page_number;
    if (r.mode == MODE_ALLOC) begin
      // The requester's list first, then the others in index order.
      k = 0;
      found = 1'b0;
      if (r.node != NodeNone) begin
        order[0] = r.node;
        k = 1;
      end
      for (int i = 0; i < 3; i++) begin
        if (i != r.node) begin
          order[k] = 2'(i);
          k++;
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (!found && has_pages[order[i]]) begin
          found = 1'b1;
          pg = head_pg[order[i]];
          nx = link_tbl[pg];
          if (nx[15] && nx[14:0] < low_page) begin
            o = {pg, STS_CORRUPT, order[i]};
          end else begin
            head_pg[order[i]] = nx[14:0];
            has_pages[order[i]] = nx[15];
            count_tbl[pg] = 8'd1;
            o = {pg, STS_ALLOC, order[i]};
          end
        end
      end
      return o;
    end
    if (pg < low_page) return {pg, STS_BADADDR, Node0};
    cnt = count_tbl[pg];
    if (r.mode == MODE_ADDREF) begin
      if (cnt != RefMax) count_tbl[pg] = cnt + 8'd1;
      return {pg, STS_REFADD, Node0};
    end
    if (r.mode == MODE_FREE) begin
      tgt = (pg < n1_start) ? Node0 : (pg < n2_start) ? Node1 : Node2;
      if (cnt == 8'd0) return {pg, STS_DOUBLE, tgt};
    end else begin
      if (r.node == NodeNone) return {pg, STS_BADADDR, Node0};
      tgt = r.node;
      if (cnt == 8'd0) cnt = 8'd1;
    end
    if (cnt > 8'd1) begin
      count_tbl[pg] = cnt - 8'd1;
      return {pg, STS_REFD, tgt};
    end
    // Last reference gone: push the page onto the target list.
    count_tbl[pg] = 8'd0;
    link_tbl[pg] = has_pages[tgt] ? {1'b1, head_pg[tgt]} : 16'd0;
    head_pg[tgt] = pg;
    has_pages[tgt] = 1'b1;
    return {pg, STS_FREED, tgt};
  endfunction

  // Page numbers biased toward the current boundaries and the top page.
  function automatic logic [14:0] pick_page();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return low_page + 15'($urandom_range(0, 63));
      4, 5: return n1_start - 15'd8 + 15'($urandom_range(0, 16));
      6: return n2_start - 15'd8 + 15'($urandom_range(0, 16));
      7: return 15'h7FFF - 15'($urandom_range(0, 15));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  // Drives one request until it is accepted, then records its expected result.
  task automatic issue(npa_req_t rq, bit typed, npa_res_t typed_res);
    npa_res_t pred;
    if (idle_ok && $urandom_range(0, 99) < 9) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pred = allocator_outcome(rq);
    pending_results.push_back(typed ? typed_res : pred);
    if (pred.status == STS_ALLOC || pred.status == STS_REFADD) begin
      held_pages.push_back(pred.page_number_res);
      if (held_pages.size() > 48) void'(held_pages.pop_front());
    end
  endtask

  // Lets the block drain, then writes all three boundary registers.
  task automatic apply_cfg(logic [14:0] fp, logic [14:0] n1, logic [14:0] n2);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_FIRST_PAGE;
    cfg_wdata_i <= fp;
    @(posedge clk_i);
    low_page = fp;
    cfg_idx_i <= CFG_NODE1_FIRST;
    cfg_wdata_i <= n1;
    @(posedge clk_i);
    n1_start = n1;
    cfg_idx_i <= CFG_NODE2_FIRST;
    cfg_wdata_i <= n2;
    @(posedge clk_i);
    n2_start = n2;
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic: mostly well-formed allocate/free/reference use, some noise.
  task automatic run_random(int count);
    npa_req_t rq;
    int       kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      rq.node = 2'($urandom_range(0, 3));
      rq.page_number = pick_page();
      if (held_pages.size() != 0 && (kind >= 30 && kind < 55 || kind >= 70 && kind < 80))
        rq.page_number = held_pages[$urandom_range(0, held_pages.size() - 1)];
      if (kind < 30) begin
        rq.mode = MODE_ALLOC;
      end else if (kind < 55) begin
        rq.mode = MODE_FREE;
      end else if (kind < 70) begin
        rq.mode = MODE_INIT;
        if ($urandom_range(0, 19) != 0) rq.node = 2'($urandom_range(0, 2));
      end else if (kind < 80) begin
        rq.mode = MODE_ADDREF;
      end else if (kind < 90) begin
        rq.mode = ($urandom_range(0, 1) != 0) ? MODE_FREE : MODE_ADDREF;
      end else begin
        rq.mode = 2'($urandom_range(0, 3));
        rq.page_number = 15'($urandom_range(0, 32767));
      end
      issue(rq, 1'b0, '0);
    end
  endtask

  // Each result is compared with the oldest outstanding request.
  always @(posedge clk_i) begin
    npa_res_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: page %0d status %0d",
               res_o.page_number_res, res_o.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.page_number_res !== want.page_number_res) begin
          $error("page_number_res: expected %0d, got %0d",
                 want.page_number_res, res_o.page_number_res);
          mismatches++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          mismatches++;
        end
        if (res_o.node_used !== want.node_used) begin
          $error("node_used: expected %0d, got %0d", want.node_used, res_o.node_used);
          mismatches++;
        end
      end
    end
  end

  initial begin
    npa_req_t rq;
    // Directed table at reset boundaries; rows with typed = 0 use the predictor.
    dir_tbl.push_back({MODE_ALLOC, 15'd0, Node0, 1'b1, 15'd0, STS_NOMEM, Node0});
    dir_tbl.push_back({MODE_ALLOC, 15'd0, NodeNone, 1'b1, 15'd0, STS_NOMEM, Node0});
    dir_tbl.push_back({MODE_FREE, 15'd5, Node0, 1'b1, 15'd5, STS_DOUBLE, Node0});
    dir_tbl.push_back({MODE_FREE, 15'd32767, Node1, 1'b1, 15'd32767, STS_DOUBLE, Node2});
    dir_tbl.push_back({MODE_ADDREF, 15'd0, Node2, 1'b1, 15'd0, STS_REFADD, Node0});
    dir_tbl.push_back({MODE_FREE, 15'd0, Node0, 1'b1, 15'd0, STS_FREED, Node0});
    dir_tbl.push_back({MODE_INIT, 15'd32767, NodeNone, 1'b1, 15'd32767, STS_BADADDR, Node0});
    dir_tbl.push_back({MODE_INIT, 15'd32767, Node2, 1'b1, 15'd32767, STS_FREED, Node2});
    dir_tbl.push_back({MODE_INIT, 15'd10923, Node1, 1'b1, 15'd10923, STS_FREED, Node1});
    dir_tbl.push_back({MODE_INIT, 15'd21845, Node1, 1'b1, 15'd21845, STS_FREED, Node1});
    dir_tbl.push_back({MODE_ADDREF, 15'd100, Node0, 1'b1, 15'd100, STS_REFADD, Node0});
    dir_tbl.push_back({MODE_ADDREF, 15'd100, Node1, 1'b1, 15'd100, STS_REFADD, Node0});
    dir_tbl.push_back({MODE_INIT, 15'd100, Node0, 1'b1, 15'd100, STS_REFD, Node0});
    dir_tbl.push_back({MODE_FREE, 15'd100, NodeNone, 1'b1, 15'd100, STS_FREED, Node0});
    dir_tbl.push_back({MODE_ALLOC, 15'd0, NodeNone, 1'b0, 20'd0});
    dir_tbl.push_back({MODE_ALLOC, 15'd0, Node1, 1'b0, 20'd0});
    dir_tbl.push_back({MODE_ALLOC, 15'd0, Node2, 1'b0, 20'd0});
    dir_tbl.push_back({MODE_ALLOC, 15'd0, Node2, 1'b0, 20'd0});
    dir_tbl.push_back({MODE_ALLOC, 15'd0, Node0, 1'b0, 20'd0});
    dir_tbl.push_back({MODE_ALLOC, 15'd0, Node1, 1'b1, 15'd0, STS_NOMEM, Node0});
    dir_tbl.push_back({MODE_ADDREF, 15'd32767, Node0, 1'b1, 15'd32767, STS_REFADD, Node0});
    dir_tbl.push_back({MODE_FREE, 15'd32767, Node0, 1'b0, 20'd0});
    dir_tbl.push_back({MODE_FREE, 15'd32767, Node0, 1'b0, 20'd0});
    dir_tbl.push_back({MODE_FREE, 15'd32767, Node0, 1'b1, 15'd32767, STS_DOUBLE, Node2});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) issue(dir_tbl[i].rq, dir_tbl[i].typed, dir_tbl[i].res);
    run_random(200);

    // Small boundaries; hammer one page past count saturation, then free it three times.
    apply_cfg(15'd100, 15'd200, 15'd300);
    rq = {MODE_ADDREF, 15'd107, Node0};
    repeat (257) issue(rq, 1'b0, '0);
    rq.mode = MODE_FREE;
    repeat (3) issue(rq, 1'b0, '0);
    run_random(200);

    // Every page in node two, back to back with no gaps.
    apply_cfg(15'd0, 15'd0, 15'd0);
    idle_ok = 1'b0;
    run_random(200);
    idle_ok = 1'b1;

    // Top page only: almost everything is out of range and old links look corrupt.
    apply_cfg(15'h7FFF, 15'h7FFF, 15'h7FFF);
    run_random(100);

    // Node two boundary below node one.
    apply_cfg(15'd4000, 15'd30000, 15'd12000);
    run_random(150);

    apply_cfg(FirstPageRst, Node1FirstRst, Node2FirstRst);
    run_random(150);

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: covers the count-table clearing pass and every request with gaps.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
